[src/rrws_pkg.sv]
package rrws_pkg;

    // sizing
    localparam int MAX_LAYERS     = 64;
    localparam int MAX_RANKS      = 16;
    localparam int ROW_COUNT_BITS = 24;

    localparam int LAYER_AW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int RANK_AW  = $clog2(MAX_RANKS);
    localparam int RADDR_W  = LAYER_AW + RANK_AW;
    localparam int K_W      = $clog2(MAX_RANKS + 1);
    localparam int CMP_W    = 8;

    // field widths
    localparam int LAYER_W    = 6;
    localparam int RANK_W     = 4;
    localparam int W_W        = 17;
    localparam int SQ_IN_W    = 2 * W_W;
    localparam int SUM_W      = 41;
    localparam int SQ_W       = 57;
    localparam int MASS_W     = 45;
    localparam int BOT_W      = 42;
    localparam int RRM_W      = 21;
    localparam int RBM_W      = 18;
    localparam int CNT_OUT_W  = 24;
    localparam int RU_W       = 5;
    localparam int TOL_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [W_W-1:0] ONE_Q16 = W_W'(65536);

    // result queue
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic {
        CMD_ACCUM = 1'b0,
        CMD_READ  = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANKS_USED  = 2'd0,
        CFG_EXPECT_NORM = 2'd1,
        CFG_ORDER_TOL   = 2'd2,
        CFG_NORM_TOL    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [RU_W-1:0]  ranks_used;
        logic             expect_norm;
        logic [TOL_W-1:0] order_tol;
        logic [TOL_W-1:0] norm_tol;
    } t_cfg;

    // stage-0 view of one accepted item
    typedef struct packed {
        logic               acc;
        logic               is_read;
        logic               close;
        logic               lay_ok;
        logic               rank_ok;
        logic               disorder;
        logic [W_W-1:0]     w;
        logic [SQ_IN_W-1:0] sq;
        logic [RRM_W-1:0]   row_mass;
        logic [RBM_W-1:0]   bot_mass;
    } t_row_info;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
    } t_rank_rec;

    typedef struct packed {
        logic [ROW_COUNT_BITS-1:0] count;
        logic [MASS_W-1:0]         mass;
        logic [BOT_W-1:0]          bottom;
        logic                      order_flag;
        logic                      norm_flag;
    } t_layer_rec;

    typedef struct packed {
        logic [SUM_W-1:0]     rank_weight_total;
        logic [SQ_W-1:0]      rank_square_total;
        logic [CNT_OUT_W-1:0] rows_seen;
        logic [MASS_W-1:0]    row_mass_total;
        logic [BOT_W-1:0]     bottom_two_total;
        logic                 order_warning;
        logic                 norm_warning;
    } t_result;

    // ranks_used clamped to 1..MAX_RANKS
    function automatic logic [K_W-1:0] eff_k(input logic [RU_W-1:0] ru);
        logic [K_W-1:0] k;
        if (ru == '0) begin
            k = K_W'(1);
        end else if (32'(ru) > MAX_RANKS) begin
            k = K_W'(MAX_RANKS);
        end else begin
            k = K_W'(ru);
        end
        return k;
    endfunction

endpackage

[src/router_rank_weight_statistics_core.sv]
// channel   direction  handshake                 payload
// cfg       in         i_cfg_we                  i_cfg_idx, i_cfg_data
// in        in         i_in_valid / o_in_ready   i_cmd, i_layer, i_rank, i_weight
// out       out        o_out_valid / i_out_ready rank/layer totals, two warnings
//
// one item per cycle while o_in_ready is high; a read result passes the stage-1 register
// into a four-entry result queue and shows on out from there; the two block rams (per
// layer+rank and per layer) do one read-modify-write per cycle with forwarding
// after reset a clearing pass zeroes the stores, walking all 2**RADDR_W = 1024 addresses
// with o_in_ready low; cfg writes are taken throughout
// outside the clearing pass, o_in_ready drops only when the result queue could overflow
module router_rank_weight_statistics_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [rrws_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rrws_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input items
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_cmd,
    input  logic [rrws_pkg::LAYER_W-1:0]     i_layer,
    input  logic [rrws_pkg::RANK_W-1:0]      i_rank,
    input  logic [rrws_pkg::W_W-1:0]         i_weight,
    // results
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [rrws_pkg::SUM_W-1:0]       o_rank_weight_total,
    output logic [rrws_pkg::SQ_W-1:0]        o_rank_square_total,
    output logic [rrws_pkg::CNT_OUT_W-1:0]   o_rows_seen,
    output logic [rrws_pkg::MASS_W-1:0]      o_row_mass_total,
    output logic [rrws_pkg::BOT_W-1:0]       o_bottom_two_total,
    output logic                             o_order_warning,
    output logic                             o_norm_warning
);

    localparam int RANK_DEPTH = 2 ** rrws_pkg::RADDR_W;
    localparam int LAYER_DEPTH = 2 ** rrws_pkg::LAYER_AW;
    localparam int RANK_RW = $bits(rrws_pkg::t_rank_rec);
    localparam int LAYER_RW = $bits(rrws_pkg::t_layer_rec);

    // configuration registers
    rrws_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ranks_used  <= rrws_pkg::RU_W'(8);
            r_cfg.expect_norm <= 1'b0;
            r_cfg.order_tol   <= rrws_pkg::TOL_W'(7);
            r_cfg.norm_tol    <= rrws_pkg::TOL_W'(655);
        end else if (i_cfg_we) begin
            unique case (rrws_pkg::t_cfg_idx'(i_cfg_idx))
                rrws_pkg::CFG_RANKS_USED:  r_cfg.ranks_used  <= i_cfg_data[rrws_pkg::RU_W-1:0];
                rrws_pkg::CFG_EXPECT_NORM: r_cfg.expect_norm <= i_cfg_data[0];
                rrws_pkg::CFG_ORDER_TOL:   r_cfg.order_tol   <= i_cfg_data[rrws_pkg::TOL_W-1:0];
                rrws_pkg::CFG_NORM_TOL:    r_cfg.norm_tol    <= i_cfg_data[rrws_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // clearing pass after reset
    logic                          r_clr_busy;
    logic [rrws_pkg::RADDR_W-1:0]  r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + rrws_pkg::RADDR_W'(1);
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // stage 0: accept, row tracking, issue memory reads
    logic                             take;
    rrws_pkg::t_row_info              info;
    logic [rrws_pkg::RADDR_W-1:0]     rank_raddr;
    logic [rrws_pkg::LAYER_AW-1:0]    layer_raddr;
    logic [rrws_pkg::OUTQ_CW-1:0]     q_count;
    logic                             r_s1_read;

    assign take        = i_in_valid && o_in_ready;
    assign rank_raddr  = {rrws_pkg::LAYER_AW'(i_layer), rrws_pkg::RANK_AW'(i_rank)};
    assign layer_raddr = rrws_pkg::LAYER_AW'(i_layer);

    // a read in flight holds a slot in the result queue
    assign o_in_ready = !r_clr_busy
                     && (({1'b0, q_count} + (rrws_pkg::OUTQ_CW + 1)'(r_s1_read))
                         < (rrws_pkg::OUTQ_CW + 1)'(rrws_pkg::OUTQ_DEPTH));

    rrws_row_track u_row_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_cmd    (i_cmd),
        .i_layer  (i_layer),
        .i_rank   (i_rank),
        .i_weight (i_weight),
        .i_cfg    (r_cfg),
        .o_info   (info)
    );

    // stage 1 registers
    logic                             r_s1_acc;
    rrws_pkg::t_row_info              r_s1_info;
    logic [rrws_pkg::RADDR_W-1:0]     r_s1_raddr;
    logic [rrws_pkg::LAYER_AW-1:0]    r_s1_laddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_acc  <= 1'b0;
            r_s1_read <= 1'b0;
        end else begin
            r_s1_acc  <= take && info.acc;
            r_s1_read <= take && info.is_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_info  <= info;
            r_s1_raddr <= rank_raddr;
            r_s1_laddr <= layer_raddr;
        end
    end

    // stores
    rrws_pkg::t_rank_rec              rank_q, rank_cur, n_rank;
    rrws_pkg::t_layer_rec             layer_q, layer_cur, n_layer;
    logic                             rank_we, layer_we;
    logic                             item_rank_we, item_layer_we;
    logic [rrws_pkg::RADDR_W-1:0]     rank_waddr;
    logic [rrws_pkg::LAYER_AW-1:0]    layer_waddr;
    rrws_pkg::t_rank_rec              rank_wdata;
    rrws_pkg::t_layer_rec             layer_wdata;

    assign item_rank_we  = r_s1_acc;
    assign item_layer_we = r_s1_acc && r_s1_info.close;
    assign rank_we       = r_clr_busy || item_rank_we;
    assign layer_we      = r_clr_busy || item_layer_we;
    assign rank_waddr    = r_clr_busy ? r_clr_addr : r_s1_raddr;
    assign layer_waddr   = r_clr_busy ? r_clr_addr[rrws_pkg::LAYER_AW-1:0] : r_s1_laddr;
    assign rank_wdata    = r_clr_busy ? '0 : n_rank;
    assign layer_wdata   = r_clr_busy ? '0 : n_layer;

    rrws_ram #(
        .WIDTH (RANK_RW),
        .DEPTH (RANK_DEPTH)
    ) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (rank_we),
        .i_waddr (rank_waddr),
        .i_wdata (rank_wdata),
        .i_re    (take),
        .i_raddr (rank_raddr),
        .o_rdata (rank_q)
    );

    rrws_ram #(
        .WIDTH (LAYER_RW),
        .DEPTH (LAYER_DEPTH)
    ) u_layer_ram (
        .i_clk   (i_clk),
        .i_we    (layer_we),
        .i_waddr (layer_waddr),
        .i_wdata (layer_wdata),
        .i_re    (take),
        .i_raddr (layer_raddr),
        .o_rdata (layer_q)
    );

    // forwarding: the item right behind a write read the old entry
    logic                             r_rfwd_vld, r_lfwd_vld;
    logic [rrws_pkg::RADDR_W-1:0]     r_rfwd_addr;
    logic [rrws_pkg::LAYER_AW-1:0]    r_lfwd_addr;
    rrws_pkg::t_rank_rec              r_rfwd_data;
    rrws_pkg::t_layer_rec             r_lfwd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rfwd_vld <= 1'b0;
            r_lfwd_vld <= 1'b0;
        end else begin
            r_rfwd_vld <= item_rank_we;
            r_lfwd_vld <= item_layer_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rfwd_addr <= r_s1_raddr;
        r_rfwd_data <= n_rank;
        r_lfwd_addr <= r_s1_laddr;
        r_lfwd_data <= n_layer;
    end

    // stage 1: modify with saturation
    logic [rrws_pkg::SUM_W:0]         sum_ext;
    logic [rrws_pkg::SQ_W:0]          sq_ext;
    logic [rrws_pkg::MASS_W:0]        mass_ext;
    logic [rrws_pkg::BOT_W:0]         bot_ext;
    logic [rrws_pkg::RRM_W-1:0]       one_ext;
    logic [rrws_pkg::RRM_W-1:0]       dev;
    logic                             norm_bad;
    rrws_pkg::t_result                res;

    always_comb begin
        rank_cur  = (r_rfwd_vld && (r_rfwd_addr == r_s1_raddr)) ? r_rfwd_data : rank_q;
        layer_cur = (r_lfwd_vld && (r_lfwd_addr == r_s1_laddr)) ? r_lfwd_data : layer_q;

        sum_ext  = {1'b0, rank_cur.sum} + (rrws_pkg::SUM_W + 1)'(r_s1_info.w);
        sq_ext   = {1'b0, rank_cur.sq} + (rrws_pkg::SQ_W + 1)'(r_s1_info.sq);
        mass_ext = {1'b0, layer_cur.mass} + (rrws_pkg::MASS_W + 1)'(r_s1_info.row_mass);
        bot_ext  = {1'b0, layer_cur.bottom} + (rrws_pkg::BOT_W + 1)'(r_s1_info.bot_mass);

        // distance of the row sum from one
        one_ext  = rrws_pkg::RRM_W'(rrws_pkg::ONE_Q16);
        dev      = (r_s1_info.row_mass >= one_ext) ? (r_s1_info.row_mass - one_ext)
                                                   : (one_ext - r_s1_info.row_mass);
        norm_bad = r_cfg.expect_norm && (dev > rrws_pkg::RRM_W'(r_cfg.norm_tol));

        n_rank.sum = sum_ext[rrws_pkg::SUM_W] ? '1 : sum_ext[rrws_pkg::SUM_W-1:0];
        n_rank.sq  = sq_ext[rrws_pkg::SQ_W] ? '1 : sq_ext[rrws_pkg::SQ_W-1:0];

        n_layer.count      = (&layer_cur.count) ? layer_cur.count
                           : layer_cur.count + rrws_pkg::ROW_COUNT_BITS'(1);
        n_layer.mass       = mass_ext[rrws_pkg::MASS_W] ? '1 : mass_ext[rrws_pkg::MASS_W-1:0];
        n_layer.bottom     = bot_ext[rrws_pkg::BOT_W] ? '1 : bot_ext[rrws_pkg::BOT_W-1:0];
        n_layer.order_flag = layer_cur.order_flag || r_s1_info.disorder;
        n_layer.norm_flag  = layer_cur.norm_flag || norm_bad;

        // read result; out-of-range layer or rank fields read as zero
        res = '0;
        if (r_s1_info.lay_ok) begin
            if (r_s1_info.rank_ok) begin
                res.rank_weight_total = rank_cur.sum;
                res.rank_square_total = rank_cur.sq;
            end
            res.rows_seen        = rrws_pkg::CNT_OUT_W'(layer_cur.count);
            res.row_mass_total   = layer_cur.mass;
            res.bottom_two_total = layer_cur.bottom;
            res.order_warning    = layer_cur.order_flag;
            res.norm_warning     = layer_cur.norm_flag;
        end
    end

    // result queue
    rrws_pkg::t_result q_data;

    rrws_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_read),
        .i_data  (res),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_rank_weight_total = q_data.rank_weight_total;
    assign o_rank_square_total = q_data.rank_square_total;
    assign o_rows_seen         = q_data.rows_seen;
    assign o_row_mass_total    = q_data.row_mass_total;
    assign o_bottom_two_total  = q_data.bottom_two_total;
    assign o_order_warning     = q_data.order_warning;
    assign o_norm_warning      = q_data.norm_warning;

endmodule

[src/rrws_ram.sv]
module rrws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/rrws_row_track.sv]
module rrws_row_track (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic                         i_cmd,
    input  logic [rrws_pkg::LAYER_W-1:0] i_layer,
    input  logic [rrws_pkg::RANK_W-1:0]  i_rank,
    input  logic [rrws_pkg::W_W-1:0]     i_weight,
    input  rrws_pkg::t_cfg               i_cfg,
    output rrws_pkg::t_row_info          o_info
);

    logic [rrws_pkg::K_W-1:0]     k;
    logic [rrws_pkg::CMP_W-1:0]   rank_x;
    logic [rrws_pkg::CMP_W-1:0]   k_x;
    logic [rrws_pkg::W_W-1:0]     w;
    logic                         lay_ok;
    logic                         acc;
    logic                         open_row;
    logic                         bottom;
    logic [rrws_pkg::W_W:0]       limit;
    logic [rrws_pkg::RRM_W-1:0]   row_base;
    logic [rrws_pkg::RBM_W-1:0]   bot_base;

    logic [rrws_pkg::W_W-1:0]     r_prev_w, n_prev_w;
    logic [rrws_pkg::RRM_W-1:0]   r_row_mass, n_row_mass;
    logic [rrws_pkg::RBM_W-1:0]   r_bot_mass, n_bot_mass;
    logic                         r_disorder, n_disorder;

    always_comb begin
        k        = rrws_pkg::eff_k(i_cfg.ranks_used);
        rank_x   = rrws_pkg::CMP_W'(i_rank);
        k_x      = rrws_pkg::CMP_W'(k);
        w        = (i_weight > rrws_pkg::ONE_Q16) ? rrws_pkg::ONE_Q16 : i_weight;
        lay_ok   = 32'(i_layer) < rrws_pkg::MAX_LAYERS;
        acc      = (i_cmd == rrws_pkg::CMD_ACCUM) && lay_ok && (rank_x < k_x);
        open_row = rank_x == '0;
        // last two ranks, or rank 0 alone for single-rank rows
        bottom   = (k_x < rrws_pkg::CMP_W'(2)) || (rank_x >= (k_x - rrws_pkg::CMP_W'(2)));
        limit    = {1'b0, r_prev_w} + (rrws_pkg::W_W + 1)'(i_cfg.order_tol);
        row_base = open_row ? '0 : r_row_mass;
        bot_base = open_row ? '0 : r_bot_mass;

        n_prev_w   = w;
        n_disorder = open_row ? 1'b0 : (r_disorder || ({1'b0, w} > limit));
        n_row_mass = row_base + rrws_pkg::RRM_W'(w);
        n_bot_mass = bottom ? (bot_base + rrws_pkg::RBM_W'(w)) : bot_base;

        o_info.acc      = acc;
        o_info.is_read  = i_cmd == rrws_pkg::CMD_READ;
        o_info.close    = rank_x == (k_x - rrws_pkg::CMP_W'(1));
        o_info.lay_ok   = lay_ok;
        o_info.rank_ok  = 32'(i_rank) < rrws_pkg::MAX_RANKS;
        o_info.disorder = n_disorder;
        o_info.w        = w;
        o_info.sq       = rrws_pkg::SQ_IN_W'(w) * rrws_pkg::SQ_IN_W'(w);
        o_info.row_mass = n_row_mass;
        o_info.bot_mass = n_bot_mass;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_w   <= '0;
            r_row_mass <= '0;
            r_bot_mass <= '0;
            r_disorder <= 1'b0;
        end else if (i_take && acc) begin
            r_prev_w   <= n_prev_w;
            r_row_mass <= n_row_mass;
            r_bot_mass <= n_bot_mass;
            r_disorder <= n_disorder;
        end
    end

endmodule

[src/rrws_out_queue.sv]
module rrws_out_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  rrws_pkg::t_result              i_data,
    input  logic                           i_pop,
    output logic                           o_valid,
    output rrws_pkg::t_result              o_data,
    output logic [rrws_pkg::OUTQ_CW-1:0]   o_count
);

    rrws_pkg::t_result               r_mem [rrws_pkg::OUTQ_DEPTH];
    logic [rrws_pkg::OUTQ_PW-1:0]    r_wp;
    logic [rrws_pkg::OUTQ_PW-1:0]    r_rp;
    logic [rrws_pkg::OUTQ_CW-1:0]    r_cnt;
    logic                            pop_ok;

    assign pop_ok  = i_pop && (r_cnt != '0);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + rrws_pkg::OUTQ_PW'(1);
            end
            if (pop_ok) begin
                r_rp <= r_rp + rrws_pkg::OUTQ_PW'(1);
            end
            if (i_push && !pop_ok) begin
                r_cnt <= r_cnt + rrws_pkg::OUTQ_CW'(1);
            end else if (!i_push && pop_ok) begin
                r_cnt <= r_cnt - rrws_pkg::OUTQ_CW'(1);
            end
        end
    end

endmodule

[src/rrws_checker.sv]
module rrws_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_we,
    input logic [rrws_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input logic [rrws_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic                             i_cmd,
    input logic [rrws_pkg::LAYER_W-1:0]     i_layer,
    input logic [rrws_pkg::RANK_W-1:0]      i_rank,
    input logic [rrws_pkg::W_W-1:0]         i_weight,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [rrws_pkg::SUM_W-1:0]       o_rank_weight_total,
    input logic [rrws_pkg::SQ_W-1:0]        o_rank_square_total,
    input logic [rrws_pkg::CNT_OUT_W-1:0]   o_rows_seen,
    input logic [rrws_pkg::MASS_W-1:0]      o_row_mass_total,
    input logic [rrws_pkg::BOT_W-1:0]       o_bottom_two_total,
    input logic                             o_order_warning,
    input logic                             o_norm_warning
);

    logic read_xfer;

    assign read_xfer = i_in_valid && o_in_ready && (i_cmd == rrws_pkg::CMD_READ);

    // clearing pass blocks input right after reset
    a_no_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready right after reset");

    // a result appearing on an empty output comes from an earlier read transfer
    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(read_xfer, 2))
        else $error("result without a matching read");

    // a layer with no closed rows has no row totals and no warnings
    a_empty_layer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_rows_seen == '0)) |->
            ((o_row_mass_total == '0) && (o_bottom_two_total == '0)
             && !o_order_warning && !o_norm_warning))
        else $error("layer totals without any closed row");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_rank_weight_total) && $stable(o_rows_seen)))
        else $error("stalled result changed");

endmodule

bind router_rank_weight_statistics_core rrws_checker u_rrws_checker (.*);
